// ===== rtl/ble_crcw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ble_crcw_pkg
// Shared constants and byte-wide CRC-24 / whitening helpers for the BLE
// advertising packet framer.
// ----------------------------------------------------------------------------
package ble_crcw_pkg;

  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_CHANNEL   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ACC_ADDR  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_CRC_INIT  = 2'd2;

  localparam logic [5:0]  CHANNEL_RST  = 6'd37;
  localparam logic [31:0] ACC_ADDR_RST = 32'h6B7D_9171;
  localparam logic [23:0] CRC_INIT_RST = 24'hAA_AAAA;

  localparam logic [7:0]  FRAME_LEAD   = 8'h07;
  localparam logic [7:0]  PREAMBLE     = 8'h55;
  localparam logic [7:0]  SUFFIX_BYTE  = 8'h1C;
  localparam logic [23:0] CRC_TAPS     = 24'h5A_6000;

  typedef struct packed {
    logic [6:0] lfsr;
    logic [7:0] data;
  } whiten_t;

  // crc update over one byte, bit 7 first
  function automatic logic [23:0] crc_byte(input logic [23:0] crc_in,
                                           input logic [7:0] data);
    logic [23:0] crc;
    logic        c;
    crc = crc_in;
    for (int k = 7; k >= 0; k--) begin
      c   = crc[0] ^ data[k];
      crc = {c, crc[23:1]} ^ (c ? CRC_TAPS : 24'd0);
    end
    return crc;
  endfunction

  // whitening of one byte, bit 7 first
  function automatic whiten_t whiten_byte(input logic [6:0] lfsr_in,
                                          input logic [7:0] data);
    whiten_t res;
    logic    b0;
    res.lfsr = lfsr_in;
    res.data = data;
    for (int k = 7; k >= 0; k--) begin
      b0          = res.lfsr[0];
      res.data[k] = res.data[k] ^ b0;
      res.lfsr    = {b0, res.lfsr[6:1]} ^ {4'd0, b0, 2'd0};
    end
    return res;
  endfunction

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) begin
      r[k] = v[7-k];
    end
    return r;
  endfunction

endpackage

// ===== rtl/ble_adv_packet_crc_whitener_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ble_adv_packet_crc_whitener_top
// Frames BLE advertising PDU bytes: framing bytes, CRC-24, whitening, suffix.
// ----------------------------------------------------------------------------
// path: an input byte waits in the item register, output bytes in the
//   single output register; throughput: one output byte per cycle while
//   out_ready_i is high. A first pdu byte follows lead, preamble and
//   address bytes; a final one is trailed by three crc bytes and suffix
// reset: config registers return to channel 37, default access address and
//   crc init; no packet open, no word held
module ble_adv_packet_crc_whitener_top
  import ble_crcw_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         pdu_byte_i,
  input  logic               final_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         out_byte_o,
  output logic               run_last_o,
  output logic               packet_end_o
);

  typedef enum logic [3:0] {
    PH_PRE, PH_PREAMBLE, PH_AA3, PH_AA2, PH_AA1, PH_AA0,
    PH_PDU, PH_CRC0, PH_CRC1, PH_CRC2, PH_SUFFIX
  } phase_e;

  logic [5:0]  channel_q;
  logic [31:0] acc_addr_q;
  logic [23:0] crc_init_q;

  logic        item_vld_q, item_vld_d;
  logic [7:0]  item_byte_q;
  logic        item_final_q;
  phase_e      phase_q, phase_d;

  logic [23:0] crc_q, crc_d;
  logic [6:0]  lfsr_q, lfsr_d;
  logic        in_packet_q, in_packet_d;

  logic        out_vld_q, out_vld_d;
  logic [7:0]  out_byte_q, out_byte_d;
  logic        run_last_q, run_last_d;
  logic        pkt_end_q, pkt_end_d;

  logic        emit;
  logic        item_done;
  whiten_t     wh;
  logic [7:0]  wh_src;
  logic        in_take;

  assign cfg_ready_o = 1'b1;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channel_q  <= CHANNEL_RST;
      acc_addr_q <= ACC_ADDR_RST;
      crc_init_q <= CRC_INIT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_CHANNEL:  channel_q  <= cfg_data_i[5:0];
        CFG_ACC_ADDR: acc_addr_q <= cfg_data_i;
        CFG_CRC_INIT: crc_init_q <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  assign emit    = item_vld_q && (!out_vld_q || out_ready_i);
  assign in_take = in_valid_i && in_ready_o;

  always_comb begin
    unique case (phase_q)
      PH_CRC0: wh_src = rev8(crc_q[7:0]);
      PH_CRC1: wh_src = rev8(crc_q[15:8]);
      PH_CRC2: wh_src = rev8(crc_q[23:16]);
      default: wh_src = item_byte_q;
    endcase
  end

  assign wh = whiten_byte(lfsr_q, wh_src);

  always_comb begin
    phase_d     = phase_q;
    crc_d       = crc_q;
    lfsr_d      = lfsr_q;
    in_packet_d = in_packet_q;
    out_vld_d   = out_vld_q && !out_ready_i;
    out_byte_d  = out_byte_q;
    run_last_d  = run_last_q;
    pkt_end_d   = pkt_end_q;
    item_done   = 1'b0;

    if (emit) begin
      out_vld_d  = 1'b1;
      run_last_d = 1'b0;
      pkt_end_d  = 1'b0;
      unique case (phase_q)
        PH_PRE: begin
          out_byte_d = FRAME_LEAD;
          crc_d      = crc_init_q;
          lfsr_d     = {1'b1, channel_q};
          phase_d    = PH_PREAMBLE;
        end
        PH_PREAMBLE: begin
          out_byte_d = PREAMBLE;
          phase_d    = PH_AA3;
        end
        PH_AA3: begin
          out_byte_d = acc_addr_q[31:24];
          phase_d    = PH_AA2;
        end
        PH_AA2: begin
          out_byte_d = acc_addr_q[23:16];
          phase_d    = PH_AA1;
        end
        PH_AA1: begin
          out_byte_d = acc_addr_q[15:8];
          phase_d    = PH_AA0;
        end
        PH_AA0: begin
          out_byte_d = acc_addr_q[7:0];
          phase_d    = PH_PDU;
        end
        PH_PDU: begin
          out_byte_d  = wh.data;
          lfsr_d      = wh.lfsr;
          crc_d       = crc_byte(crc_q, item_byte_q);
          in_packet_d = 1'b1;
          phase_d     = PH_CRC0;
          if (!item_final_q) begin
            run_last_d = 1'b1;
            item_done  = 1'b1;
          end
        end
        PH_CRC0: begin
          out_byte_d = wh.data;
          lfsr_d     = wh.lfsr;
          phase_d    = PH_CRC1;
        end
        PH_CRC1: begin
          out_byte_d = wh.data;
          lfsr_d     = wh.lfsr;
          phase_d    = PH_CRC2;
        end
        PH_CRC2: begin
          out_byte_d = wh.data;
          lfsr_d     = wh.lfsr;
          phase_d    = PH_SUFFIX;
        end
        PH_SUFFIX: begin
          out_byte_d  = SUFFIX_BYTE;
          run_last_d  = 1'b1;
          pkt_end_d   = 1'b1;
          in_packet_d = 1'b0;
          item_done   = 1'b1;
        end
        default: ;
      endcase
    end

    item_vld_d = item_vld_q && !item_done;
    if (in_take) begin
      item_vld_d = 1'b1;
      phase_d    = in_packet_d ? PH_PDU : PH_PRE;
    end
  end

  assign in_ready_o = !item_vld_q || item_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q  <= 1'b0;
      phase_q     <= PH_PRE;
      in_packet_q <= 1'b0;
      out_vld_q   <= 1'b0;
      crc_q       <= CRC_INIT_RST;
      lfsr_q      <= {1'b1, CHANNEL_RST};
    end else begin
      item_vld_q  <= item_vld_d;
      phase_q     <= phase_d;
      in_packet_q <= in_packet_d;
      out_vld_q   <= out_vld_d;
      crc_q       <= crc_d;
      lfsr_q      <= lfsr_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_byte_q  <= pdu_byte_i;
      item_final_q <= final_byte_i;
    end
    out_byte_q <= out_byte_d;
    run_last_q <= run_last_d;
    pkt_end_q  <= pkt_end_d;
  end

  assign out_valid_o  = out_vld_q;
  assign out_byte_o   = out_byte_q;
  assign run_last_o   = run_last_q;
  assign packet_end_o = pkt_end_q;

  // assertions
  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && pkt_end_q |-> run_last_q)
    else $error("packet end without run last");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_vld_q && out_vld_q && !out_ready_i |-> !in_ready_o)
    else $error("input taken while output stalled");

  a_crc_in_packet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_vld_q && phase_q == PH_CRC0 |-> in_packet_q)
    else $error("crc phase outside packet");

  a_pre_outside_packet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_vld_q && phase_q == PH_PRE |-> !in_packet_q)
    else $error("framing phase inside packet");

endmodule
